[design/mqf_pkg.sv]
// ---------------------------------------------------------------------------
// mqf_pkg
// Shared opcode and status codes and the per-item result record of the
// multi-queue FIFO.
// ---------------------------------------------------------------------------
package mqf_pkg;

  localparam int DATA_W  = 32;
  localparam int QIDX_W  = 2;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   lost;
    logic                use_rd;
  } result_t;

endpackage

[design/mqf_word_ram.sv]
// ---------------------------------------------------------------------------
// mqf_word_ram
// Single-port word store with a registered read.
// ---------------------------------------------------------------------------
module mqf_word_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       we,
  input  logic [AW-1:0]              addr,
  input  logic [mqf_pkg::DATA_W-1:0] wdata,
  output logic [mqf_pkg::DATA_W-1:0] rdata
);

  logic [mqf_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[design/mqf_queue_ctrl.sv]
// ---------------------------------------------------------------------------
// mqf_queue_ctrl
// Per-queue pointers, fill counts and dropped-write counters. Decodes one
// item, updates the addressed queue and issues the word store access.
// ---------------------------------------------------------------------------
module mqf_queue_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_QUEUES  = 4,
  parameter int AW          = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [mqf_pkg::OP_W-1:0]   opcode,
  input  logic [mqf_pkg::QIDX_W-1:0] queue_index,
  input  logic [mqf_pkg::DATA_W-1:0] write_data,
  output logic                       mem_en,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_addr,
  output logic [mqf_pkg::DATA_W-1:0] mem_wdata,
  output mqf_pkg::result_t           result
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  logic [PW-1:0]              rptr [NUM_QUEUES];
  logic [PW-1:0]              wptr [NUM_QUEUES];
  logic [FW-1:0]              fill [NUM_QUEUES];
  logic [mqf_pkg::DATA_W-1:0] drop [NUM_QUEUES];

  logic [QW-1:0]              q_sel;
  logic                       q_ok;
  mqf_pkg::opcode_t           op;
  logic [PW-1:0]              rptr_cur;
  logic [PW-1:0]              wptr_cur;
  logic [FW-1:0]              fill_cur;
  logic [mqf_pkg::DATA_W-1:0] drop_cur;
  logic                       full;
  logic                       empty;
  logic [PW-1:0]              rptr_next;
  logic [PW-1:0]              wptr_next;
  logic [PW-1:0]              slot;

  assign q_sel = QW'(queue_index);
  assign q_ok  = (32'(queue_index) < NUM_QUEUES);
  assign op    = mqf_pkg::opcode_t'(opcode);

  assign rptr_cur = rptr[q_sel];
  assign wptr_cur = wptr[q_sel];
  assign fill_cur = fill[q_sel];
  assign drop_cur = drop[q_sel];
  assign full     = (fill_cur == FW'(QUEUE_DEPTH));
  assign empty    = (fill_cur == '0);

  assign rptr_next = (rptr_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_cur + PW'(1);
  assign wptr_next = (wptr_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_cur + PW'(1);

  always_comb begin
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    slot          = rptr_cur;
    result.status = mqf_pkg::ST_OK;
    result.lost   = '0;
    result.use_rd = 1'b0;
    if (q_ok) begin
      result.lost = drop_cur;
      case (op)
        mqf_pkg::OP_INIT: begin
          result.lost = '0;
        end
        mqf_pkg::OP_WRITE: begin
          if (full) begin
            result.status = mqf_pkg::ST_FULL;
            result.lost   = drop_cur + 32'd1;
          end else begin
            mem_en = accept;
            mem_we = 1'b1;
            slot   = wptr_cur;
          end
        end
        mqf_pkg::OP_READ: begin
          if (empty) begin
            result.status = mqf_pkg::ST_EMPTY;
          end else begin
            mem_en        = accept;
            result.use_rd = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign mem_addr  = AW'(int'(q_sel) * QUEUE_DEPTH + int'(slot));
  assign mem_wdata = write_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        rptr[i] <= '0;
        wptr[i] <= '0;
        fill[i] <= '0;
        drop[i] <= '0;
      end
    end else if (accept && q_ok) begin
      case (op)
        mqf_pkg::OP_INIT: begin
          rptr[q_sel] <= '0;
          wptr[q_sel] <= '0;
          fill[q_sel] <= '0;
          drop[q_sel] <= '0;
        end
        mqf_pkg::OP_WRITE: begin
          if (full) begin
            drop[q_sel] <= drop_cur + 32'd1;
          end else begin
            wptr[q_sel] <= wptr_next;
            fill[q_sel] <= fill_cur + FW'(1);
          end
        end
        mqf_pkg::OP_READ: begin
          if (!empty) begin
            rptr[q_sel] <= rptr_next;
            fill[q_sel] <= fill_cur - FW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[design/multi_queue_fifo_with_loss_count.sv]
// ---------------------------------------------------------------------------
// multi_queue_fifo_with_loss_count
// Several independent circular FIFOs of 32-bit words in one shared store,
// with a dropped-write counter per queue.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries opcode, queue_index and
//   write_data; an item is taken when in_valid is high and in_stall low.
//   Output channel (out_valid/out_stall) returns one item per input item:
//   read_data, status and lost_count, in input order.
//   Each result passes the pending register, then the output register;
//   queue state updates at the accepting edge and the store read is
//   registered, so one item is accepted every cycle while output drains.
//   A result waiting for the word store stage is held in a pending register;
//   with the output register also full and out_stall high, in_stall rises
//   and no item is accepted until the output is taken.
//   Reset clears all pointers, fill counts and dropped counters and empties
//   both result registers; the word store itself is not cleared, since
//   only written slots are ever read.
// ---------------------------------------------------------------------------
module multi_queue_fifo_with_loss_count #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_QUEUES  = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mqf_pkg::OP_W-1:0]   opcode,
  input  logic [mqf_pkg::QIDX_W-1:0] queue_index,
  input  logic [mqf_pkg::DATA_W-1:0] write_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mqf_pkg::DATA_W-1:0] read_data,
  output logic [mqf_pkg::STAT_W-1:0] status,
  output logic [mqf_pkg::DATA_W-1:0] lost_count
);

  localparam int DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  logic                       accept;
  logic                       mem_en;
  logic                       mem_we;
  logic [AW-1:0]              mem_addr;
  logic [mqf_pkg::DATA_W-1:0] mem_wdata;
  logic [mqf_pkg::DATA_W-1:0] mem_rdata;
  mqf_pkg::result_t           result;
  mqf_pkg::result_t           pend;
  logic                       pend_valid;
  logic                       move;

  assign move     = pend_valid && (!out_valid || !out_stall);
  assign in_stall = pend_valid && !move;
  assign accept   = in_valid && !in_stall;

  mqf_queue_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_QUEUES  (NUM_QUEUES),
    .AW          (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (opcode),
    .queue_index (queue_index),
    .write_data  (write_data),
    .mem_en      (mem_en),
    .mem_we      (mem_we),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .result      (result)
  );

  mqf_word_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= result;
    end
    if (move) begin
      read_data  <= pend.use_rd ? mem_rdata : '0;
      status     <= pend.status;
      lost_count <= pend.lost;
    end
  end

endmodule

[design/mqf_checker.sv]
// ---------------------------------------------------------------------------
// mqf_assert_checker
// Port-level checks of the multi-queue FIFO, bound to the top level.
// ---------------------------------------------------------------------------
module mqf_assert_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [mqf_pkg::DATA_W-1:0] read_data,
  input logic [mqf_pkg::STAT_W-1:0] status,
  input logic [mqf_pkg::DATA_W-1:0] lost_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(status)
      && $stable(lost_count))
    else $error("stalled output item changed");

  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mqf_pkg::ST_OK |-> read_data == '0)
    else $error("read data not zero on a failed operation");

  a_full_lost: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mqf_pkg::ST_FULL |-> lost_count != '0)
    else $error("dropped write reported with zero lost count");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind multi_queue_fifo_with_loss_count mqf_assert_checker u_mqf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .read_data  (read_data),
  .status     (status),
  .lost_count (lost_count)
);
